/* sv/cartridge_bank_mapper_macros.svh */
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cbm_pkg.sv */
package cbm_pkg;

    localparam int PATTERN_SLOTS     = 8;
    localparam int MAX_PROGRAM_PAGES = 64;
    localparam int DIV_STEPS         = 8;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 6;
    localparam int PRG_PAGES_W       = 7;

    // reset values of the configuration registers
    localparam logic       RST_HARDWIRED = 1'b0;
    localparam logic [5:0] RST_PRG_UNITS = 6'd2;
    localparam logic [5:0] RST_PAT_UNITS = 6'd1;
    localparam logic       RST_MIRROR_V  = 1'b0;

    localparam logic [CFG_IDX_W-1:0] REG_HARDWIRED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRG_UNITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_UNITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_V  = 2'd3;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_PPU   = 2'd2,
        ACT_INIT  = 2'd3
    } t_cbm_action;

    typedef enum logic [2:0] {
        SP_NONE  = 3'd0,
        SP_PROM  = 3'd1,
        SP_CROM  = 3'd2,
        SP_NTRAM = 3'd3,
        SP_CRAM  = 3'd4
    } t_cbm_space;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } t_cbm_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_value;
    } t_cbm_req;

    typedef struct packed {
        logic [2:0]  space;
        logic [18:0] offset;
    } t_cbm_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cbm_cmd;

    typedef struct packed {
        logic need_div;
    } t_cbm_sts;

endpackage

/* sv/cbm_ctrl.sv */
`include "cartridge_bank_mapper_macros.svh"

module cbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  cbm_pkg::t_cbm_sts i_sts,
    output cbm_pkg::t_cbm_cmd o_cmd
);
    import cbm_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    t_cbm_state           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;
    logic                 w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.need_div ? S_DIV : S_EXEC;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    `CBM_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, w_accept && i_sts.need_div, r_state == S_DIV && r_cnt == '0, "write request did not start the divider")
    `CBM_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_state == S_DIV && r_cnt == LAST_STEP, r_state == S_EXEC, "divider overran its step count")
    `CBM_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, o_cmd.commit, o_out_valid && r_state == S_IDLE, "commit did not present a result")
    `CBM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.commit, !o_out_valid || i_out_ready, "result overwritten before it was taken")

endmodule

/* sv/cbm_dp.sv */
module cbm_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  cbm_pkg::t_cbm_req                  i_in_req,
    input  cbm_pkg::t_cbm_cmd                  i_cmd,
    output cbm_pkg::t_cbm_sts                  o_sts,
    output cbm_pkg::t_cbm_rsp                  o_out_rsp
);
    import cbm_pkg::*;

    // configuration
    logic       r_hardwired;
    logic [5:0] r_prg_units;
    logic [5:0] r_pat_units;
    logic       r_mirror_v;

    // banks
    logic [7:0] r_pat_bank [PATTERN_SLOTS];
    logic [8:0] r_nt_bank  [4];
    logic [5:0] r_prg_bank [3];

    // latched request, remainder unit, result
    t_cbm_req   r_req;
    logic [8:0] r_div;
    logic [8:0] r_rem;
    logic [7:0] r_dvd;
    t_cbm_rsp   r_rsp;

    logic [PRG_PAGES_W-1:0] w_prg_pages;
    logic [8:0]             w_pat_pages;
    logic                   w_in_prg;
    logic [9:0]             w_trial;
    logic [8:0]             w_rem_next;
    logic [4:0]             w_sel;
    logic [7:0]             w_val;
    logic                   w_wr;
    logic                   w_init;
    logic [13:0]            w_pa;
    logic [8:0]             w_nb;
    logic [5:0]             w_page;
    t_cbm_rsp               w_rsp;

    always_comb begin
        if (r_prg_units == 6'd0) begin
            w_prg_pages = PRG_PAGES_W'(2);
        end else if (r_prg_units[5]) begin
            w_prg_pages = PRG_PAGES_W'(MAX_PROGRAM_PAGES);
        end else begin
            w_prg_pages = {1'b0, r_prg_units[4:0], 1'b0};
        end
    end

    assign w_pat_pages  = {r_pat_units, 3'b000};
    assign w_in_prg     = (i_in_req.address[15:13] == 3'b111);
    assign o_sts.need_div = (i_in_req.action == ACT_WRITE);

    // restoring remainder, one dividend bit a step
    assign w_trial = {r_rem, r_dvd[7]};
    always_comb begin
        if (w_trial >= {1'b0, r_div}) begin
            w_rem_next = 9'(w_trial - {1'b0, r_div});
        end else begin
            w_rem_next = w_trial[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_div <= '0;
        end else if (i_cmd.load) begin
            r_rem <= '0;
            r_div <= w_in_prg ? {2'b00, w_prg_pages} : w_pat_pages;
        end else if (i_cmd.step) begin
            r_rem <= w_rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
            r_dvd <= w_in_prg ? {2'b00, i_in_req.write_value[5:0]} : i_in_req.write_value;
        end else if (i_cmd.step) begin
            r_dvd <= {r_dvd[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hardwired <= RST_HARDWIRED;
            r_prg_units <= RST_PRG_UNITS;
            r_pat_units <= RST_PAT_UNITS;
            r_mirror_v  <= RST_MIRROR_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HARDWIRED: r_hardwired <= i_cfg_data[0];
                REG_PRG_UNITS: r_prg_units <= i_cfg_data;
                REG_PAT_UNITS: r_pat_units <= i_cfg_data;
                REG_MIRROR_V:  r_mirror_v  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_sel  = r_req.address[15:11];
    assign w_val  = r_req.write_value;
    assign w_wr   = i_cmd.commit && (r_req.action == ACT_WRITE);
    assign w_init = i_cmd.commit && (r_req.action == ACT_INIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                r_pat_bank[i] <= 8'(i);
            end
            r_nt_bank[0]  <= 9'd0;
            r_nt_bank[1]  <= {8'd0, RST_MIRROR_V};
            r_nt_bank[2]  <= {8'd0, !RST_MIRROR_V};
            r_nt_bank[3]  <= 9'd1;
            r_prg_bank[0] <= 6'd0;
            r_prg_bank[1] <= 6'd1;
            r_prg_bank[2] <= 6'({RST_PRG_UNITS, 1'b0} - 7'd2);
        end else if (w_init) begin
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                r_pat_bank[i] <= 8'(i);
            end
            r_nt_bank[0]  <= 9'd0;
            r_nt_bank[1]  <= {8'd0, r_mirror_v};
            r_nt_bank[2]  <= {8'd0, !r_mirror_v};
            r_nt_bank[3]  <= 9'd1;
            r_prg_bank[0] <= 6'd0;
            r_prg_bank[1] <= 6'd1;
            r_prg_bank[2] <= 6'(w_prg_pages - PRG_PAGES_W'(2));
        end else if (w_wr) begin
            if (w_sel[4:3] == 2'b10) begin
                if (r_pat_units != 6'd0) begin
                    r_pat_bank[w_sel[2:0]] <= r_rem[7:0];
                end
            end else if (w_sel[4:2] == 3'b110) begin
                if (!r_hardwired) begin
                    if (w_val < 8'hE0) begin
                        if (r_pat_units != 6'd0) begin
                            r_nt_bank[w_sel[1:0]] <= {1'b1, r_rem[7:0]};
                        end
                    end else begin
                        r_nt_bank[w_sel[1:0]] <= {8'd0, w_val[0]};
                    end
                end
            end else if (w_sel[4:2] == 3'b111 && w_sel[1:0] != 2'b11) begin
                r_prg_bank[w_sel[1:0]] <= r_rem[5:0];
            end
        end
    end

    // translation of reads and PPU accesses
    assign w_pa = r_req.address[13:0];
    assign w_nb = r_nt_bank[w_pa[11:10]];

    always_comb begin
        case (r_req.address[14:13])
            2'd0:    w_page = r_prg_bank[0];
            2'd1:    w_page = r_prg_bank[1];
            2'd2:    w_page = r_prg_bank[2];
            default: w_page = 6'(w_prg_pages - PRG_PAGES_W'(1));
        endcase
    end

    always_comb begin
        w_rsp = '0;
        case (r_req.action)
            ACT_READ: begin
                if (r_req.address[15]) begin
                    w_rsp.space  = SP_PROM;
                    w_rsp.offset = {w_page, r_req.address[12:0]};
                end
            end
            ACT_PPU: begin
                if (!w_pa[13]) begin
                    if (r_pat_units == 6'd0) begin
                        w_rsp.space  = SP_CRAM;
                        w_rsp.offset = 19'(w_pa[12:0]);
                    end else begin
                        w_rsp.space  = SP_CROM;
                        w_rsp.offset = 19'({r_pat_bank[w_pa[12:10]], w_pa[9:0]});
                    end
                end else if (w_pa[13:8] != 6'h3F) begin
                    if (w_nb[8]) begin
                        w_rsp.space  = SP_CROM;
                        w_rsp.offset = 19'({w_nb[7:0], w_pa[9:0]});
                    end else begin
                        w_rsp.space  = SP_NTRAM;
                        w_rsp.offset = 19'({w_nb[0], w_pa[9:0]});
                    end
                end
            end
            default: w_rsp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out_rsp = r_rsp;

endmodule

/* sv/cartridge_bank_mapper.sv */
// A CPU read, PPU or bank init request is loaded on acceptance and committed to the
//   output register from the execute state, which waits while the output is full;
//   a CPU write request first takes the steps of the bit-per-cycle remainder unit.
// Requests wait for the last commit; all bank writes share one remainder unit.
// Reset (i_rst_n low, synchronous): registers take their reset values, banks hold their
//   power-on mapping, no request is in flight and the output is empty.
module cartridge_bank_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes, only while idle
    input  logic                           i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cbm_pkg::t_cbm_req              i_in_req,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cbm_pkg::t_cbm_rsp              o_out_rsp
);
    import cbm_pkg::*;

    // Controller sequences each request: load, optional remainder steps, commit.
    // The datapath holds the config, the banks, the remainder unit and the result
    // register, so a finished result can wait while the next request is taken.
    t_cbm_cmd w_cmd;
    t_cbm_sts w_sts;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Bank writes reduce the value modulo the page count (program values first masked to
    // 6 bits; nametable values E0+ pick RAM); the last program window is the top page.
    cbm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_req   (i_in_req),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_rsp  (o_out_rsp)
    );

endmodule
